/* design/life_automaton_generation_unit_assert.svh */
// assertion macros for the life automaton generation unit
`ifndef LIFE_AUTOMATON_GENERATION_UNIT_ASSERT_SVH
`define LIFE_AUTOMATON_GENERATION_UNIT_ASSERT_SVH

`ifndef NO_ASSERTIONS

// condition must hold in the same cycle as the trigger
`define LIFEGEN_ASSERT_HOLD(lbl, clk_s, rst_s, ante, cons, msg) \
    lbl: assert property (@(posedge clk_s) disable iff (!rst_s) (ante) |-> (cons)) \
        else $error(msg);

// condition must hold in the cycle after the trigger
`define LIFEGEN_ASSERT_NEXT(lbl, clk_s, rst_s, ante, cons, msg) \
    lbl: assert property (@(posedge clk_s) disable iff (!rst_s) (ante) |=> (cons)) \
        else $error(msg);

`else

`define LIFEGEN_ASSERT_HOLD(lbl, clk_s, rst_s, ante, cons, msg)
`define LIFEGEN_ASSERT_NEXT(lbl, clk_s, rst_s, ante, cons, msg)

`endif

`endif

/* design/lifegen_pkg.sv */
package lifegen_pkg;

    // grid limits
    localparam int MAX_COLS   = 64;
    localparam int MAX_ROWS   = 64;
    localparam int CELL_COUNT = MAX_COLS * MAX_ROWS;

    // derived widths
    localparam int COL_W  = $clog2(MAX_COLS);
    localparam int ROW_W  = $clog2(MAX_ROWS);
    localparam int COLS_W = $clog2(MAX_COLS + 1);
    localparam int ROWS_W = $clog2(MAX_ROWS + 1);
    localparam int ADDR_W = $clog2(CELL_COUNT);

    // configuration port
    localparam int CFG_W      = 7;
    localparam int CFG_ADDR_W = 1;
    localparam logic [CFG_ADDR_W-1:0] REG_GRID_COLS = CFG_ADDR_W'(0);
    localparam logic [CFG_ADDR_W-1:0] REG_GRID_ROWS = CFG_ADDR_W'(1);
    localparam logic [CFG_W-1:0]      SIZE_RESET    = CFG_W'(50);

    // rule constants
    localparam int MIN_SIZE    = 3;
    localparam int BIRTH_COUNT = 3;
    localparam int SURVIVE_MIN = 2;

    typedef logic [MAX_COLS-1:0] row_t;

    typedef enum logic [1:0] {
        CMD_WRITE = 2'd0,
        CMD_READ  = 2'd1,
        CMD_STEP  = 2'd2,
        CMD_NOP   = 2'd3
    } cmd_t;

    typedef struct packed {
        logic              en;
        logic [ADDR_W-1:0] addr;
        logic              data;
    } ram_wr_t;

    typedef struct packed {
        logic              en;
        logic [ADDR_W-1:0] addr;
    } ram_rd_t;

endpackage

/* design/lifegen_cell_ram.sv */
module lifegen_cell_ram
    import lifegen_pkg::*;
(
    input  logic    clk,
    input  ram_wr_t wr,
    input  ram_rd_t rd,
    output logic    rd_data
);

    logic mem [CELL_COUNT];

    // write port
    always_ff @(posedge clk)
    begin
        if (wr.en)
        begin
            mem[wr.addr] <= wr.data;
        end
    end

    // registered read port
    always_ff @(posedge clk)
    begin
        if (rd.en)
        begin
            rd_data <= mem[rd.addr];
        end
    end

endmodule

/* design/lifegen_rule.sv */
module lifegen_rule
    import lifegen_pkg::*;
(
    input  row_t              row_up,
    input  row_t              row_mid,
    input  row_t              row_dn,
    input  logic [COL_W-1:0]  col,
    input  logic [COLS_W-1:0] cols,
    output logic              alive_next
);

    logic [COL_W-1:0] col_l;
    logic [COL_W-1:0] col_r;
    logic [3:0]       nbr_cnt;
    logic             self_alive;

    // wrapped neighbor columns
    always_comb
    begin
        col_l = (col == '0) ? COL_W'(cols - 1'b1) : col - 1'b1;
        col_r = ((COLS_W'(col) + 1'b1) == cols) ? '0 : col + 1'b1;
    end

    // neighbor count and birth / survival rule
    always_comb
    begin
        nbr_cnt = 4'(row_up[col_l]) + 4'(row_up[col]) + 4'(row_up[col_r])
                + 4'(row_mid[col_l]) + 4'(row_mid[col_r])
                + 4'(row_dn[col_l]) + 4'(row_dn[col]) + 4'(row_dn[col_r]);
        self_alive = row_mid[col];
        alive_next = (nbr_cnt == 4'(BIRTH_COUNT))
                  || (self_alive && (nbr_cnt == 4'(SURVIVE_MIN)));
    end

endmodule

/* design/life_automaton_generation_unit.sv */
// Toroidal life grid of up to 64 x 64 cells held in a single-port-write,
// registered-read cell memory. After reset the memory is swept clear, one cell
// per cycle, with busy high; configuration writes are taken during the sweep.
// A command is taken when start is high and busy is low, and its one result
// shows on done for a single cycle; the receiver cannot hold it off. Write and
// unused commands finish after the access state, a read after the access and
// read-wait states. A generation first loads the last and first rows, then for
// each row streams the row below (saved row 0 for the last row) into a register
// row buffer one cell a cycle through the memory read port and computes and
// writes back the row one cell a cycle, using the cell memory's two ports.
`include "life_automaton_generation_unit_assert.svh"

module life_automaton_generation_unit
    import lifegen_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  start,
    output logic                  busy,
    input  logic [1:0]            command,
    input  logic [5:0]            cell_x,
    input  logic [5:0]            cell_y,
    input  logic                  cell_value,
    input  logic                  cfg_wr_en,
    input  logic [CFG_ADDR_W-1:0] cfg_addr,
    input  logic [CFG_W-1:0]      cfg_wdata,
    output logic                  done,
    output logic                  cell_alive,
    output logic [1:0]            done_command
);

    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_ACCESS,
        S_READ_WAIT,
        S_LOAD,
        S_ROW,
        S_SETTLE,
        S_CALC
    } state_t;

    typedef enum logic [1:0] {
        LD_UP,
        LD_MID,
        LD_DN
    } ld_tgt_t;

    state_t            state_reg;
    logic [CFG_W-1:0]  grid_cols_reg;
    logic [CFG_W-1:0]  grid_rows_reg;
    logic [COLS_W-1:0] cols_eff;
    logic [ROWS_W-1:0] rows_eff;

    cmd_t              cmd_reg;
    logic [ADDR_W-1:0] addr_reg;
    logic              inside_reg;
    logic              value_reg;
    logic [ADDR_W-1:0] cmd_addr;
    logic              cmd_inside;
    logic [ADDR_W-1:0] last_base;

    logic [ADDR_W-1:0] clr_cnt_reg;
    logic [ADDR_W-1:0] ld_base_reg;
    logic [COL_W-1:0]  ld_cnt_reg;
    ld_tgt_t           ld_tgt_reg;
    logic              ld_pend_reg;
    logic [COL_W-1:0]  ld_idx_pend_reg;
    ld_tgt_t           ld_tgt_pend_reg;
    logic [ROW_W-1:0]  row_reg;
    logic [ADDR_W-1:0] row_base_reg;
    logic [COL_W-1:0]  col_reg;

    row_t              row_up_reg;
    row_t              row_mid_reg;
    row_t              row_dn_reg;
    row_t              row0_reg;

    logic              done_reg;
    logic              alive_reg;
    cmd_t              done_cmd_reg;

    ram_wr_t           ram_wr;
    ram_rd_t           ram_rd;
    logic              rd_data;
    logic              alive_next;
    logic              ld_last;
    logic              col_last;
    logic              row_last;

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            grid_cols_reg <= SIZE_RESET;
            grid_rows_reg <= SIZE_RESET;
        end
        else if (cfg_wr_en)
        begin
            case (cfg_addr)
                REG_GRID_COLS: grid_cols_reg <= cfg_wdata;
                REG_GRID_ROWS: grid_rows_reg <= cfg_wdata;
                default:       grid_cols_reg <= grid_cols_reg;
            endcase
        end
    end

    // clamp sizes into the supported range
    always_comb
    begin
        if (int'(grid_cols_reg) < MIN_SIZE)
            cols_eff = COLS_W'(MIN_SIZE);
        else if (int'(grid_cols_reg) > MAX_COLS)
            cols_eff = COLS_W'(MAX_COLS);
        else
            cols_eff = COLS_W'(grid_cols_reg);

        if (int'(grid_rows_reg) < MIN_SIZE)
            rows_eff = ROWS_W'(MIN_SIZE);
        else if (int'(grid_rows_reg) > MAX_ROWS)
            rows_eff = ROWS_W'(MAX_ROWS);
        else
            rows_eff = ROWS_W'(grid_rows_reg);
    end

    // command address, range check and last row base
    always_comb
    begin
        cmd_inside = (int'(cell_x) < int'(cols_eff)) && (int'(cell_y) < int'(rows_eff));
        cmd_addr   = ADDR_W'(cell_y) * ADDR_W'(cols_eff) + ADDR_W'(cell_x);
        last_base  = ADDR_W'(rows_eff - 1'b1) * ADDR_W'(cols_eff);
    end

    // end-of-row and end-of-grid flags
    always_comb
    begin
        ld_last  = (COLS_W'(ld_cnt_reg) + 1'b1) == cols_eff;
        col_last = (COLS_W'(col_reg) + 1'b1) == cols_eff;
        row_last = (ROWS_W'(row_reg) + 1'b1) == rows_eff;
    end

    // memory port control
    always_comb
    begin
        ram_wr = '0;
        ram_rd = '0;
        case (state_reg)
            S_CLEAR:
            begin
                ram_wr.en   = 1'b1;
                ram_wr.addr = clr_cnt_reg;
                ram_wr.data = 1'b0;
            end
            S_ACCESS:
            begin
                ram_wr.en   = (cmd_reg == CMD_WRITE) && inside_reg;
                ram_wr.addr = addr_reg;
                ram_wr.data = value_reg;
                ram_rd.en   = (cmd_reg == CMD_READ);
                ram_rd.addr = addr_reg;
            end
            S_LOAD:
            begin
                ram_rd.en   = 1'b1;
                ram_rd.addr = ld_base_reg + ADDR_W'(ld_cnt_reg);
            end
            S_CALC:
            begin
                ram_wr.en   = 1'b1;
                ram_wr.addr = row_base_reg + ADDR_W'(col_reg);
                ram_wr.data = alive_next;
            end
            default:
            begin
                ram_wr = '0;
                ram_rd = '0;
            end
        endcase
    end

    lifegen_cell_ram u_cell_ram (
        .clk     (clk),
        .wr      (ram_wr),
        .rd      (ram_rd),
        .rd_data (rd_data)
    );

    lifegen_rule u_rule (
        .row_up     (row_up_reg),
        .row_mid    (row_mid_reg),
        .row_dn     (row_dn_reg),
        .col        (col_reg),
        .cols       (cols_eff),
        .alive_next (alive_next)
    );

    // sequencer and result registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= S_CLEAR;
            clr_cnt_reg <= '0;
            done_reg    <= 1'b0;
            ld_pend_reg <= 1'b0;
        end
        else
        begin
            done_reg        <= 1'b0;
            ld_pend_reg     <= (state_reg == S_LOAD);
            ld_idx_pend_reg <= ld_cnt_reg;
            ld_tgt_pend_reg <= ld_tgt_reg;
            case (state_reg)
                S_CLEAR:
                begin
                    clr_cnt_reg <= clr_cnt_reg + 1'b1;
                    if (clr_cnt_reg == ADDR_W'(CELL_COUNT - 1))
                        state_reg <= S_IDLE;
                end
                S_IDLE:
                begin
                    if (start)
                    begin
                        cmd_reg    <= cmd_t'(command);
                        addr_reg   <= cmd_addr;
                        inside_reg <= cmd_inside;
                        value_reg  <= cell_value;
                        state_reg  <= S_ACCESS;
                    end
                end
                S_ACCESS:
                begin
                    case (cmd_reg)
                        CMD_READ:
                        begin
                            state_reg <= S_READ_WAIT;
                        end
                        CMD_STEP:
                        begin
                            ld_base_reg  <= last_base;
                            ld_cnt_reg   <= '0;
                            ld_tgt_reg   <= LD_UP;
                            row_reg      <= '0;
                            row_base_reg <= '0;
                            state_reg    <= S_LOAD;
                        end
                        default:
                        begin
                            done_reg     <= 1'b1;
                            alive_reg    <= 1'b0;
                            done_cmd_reg <= cmd_reg;
                            state_reg    <= S_IDLE;
                        end
                    endcase
                end
                S_READ_WAIT:
                begin
                    done_reg     <= 1'b1;
                    alive_reg    <= inside_reg & rd_data;
                    done_cmd_reg <= cmd_reg;
                    state_reg    <= S_IDLE;
                end
                S_LOAD:
                begin
                    if (ld_last)
                    begin
                        ld_cnt_reg <= '0;
                        case (ld_tgt_reg)
                            LD_UP:
                            begin
                                ld_tgt_reg  <= LD_MID;
                                ld_base_reg <= '0;
                            end
                            LD_MID:  state_reg <= S_ROW;
                            default: state_reg <= S_SETTLE;
                        endcase
                    end
                    else
                    begin
                        ld_cnt_reg <= ld_cnt_reg + 1'b1;
                    end
                end
                S_ROW:
                begin
                    if (row_last)
                    begin
                        col_reg   <= '0;
                        state_reg <= S_CALC;
                    end
                    else
                    begin
                        ld_base_reg <= row_base_reg + ADDR_W'(cols_eff);
                        ld_tgt_reg  <= LD_DN;
                        ld_cnt_reg  <= '0;
                        state_reg   <= S_LOAD;
                    end
                end
                S_SETTLE:
                begin
                    col_reg   <= '0;
                    state_reg <= S_CALC;
                end
                S_CALC:
                begin
                    if (col_last)
                    begin
                        if (row_last)
                        begin
                            done_reg     <= 1'b1;
                            alive_reg    <= 1'b0;
                            done_cmd_reg <= cmd_reg;
                            state_reg    <= S_IDLE;
                        end
                        else
                        begin
                            row_reg      <= row_reg + 1'b1;
                            row_base_reg <= row_base_reg + ADDR_W'(cols_eff);
                            state_reg    <= S_ROW;
                        end
                    end
                    else
                    begin
                        col_reg <= col_reg + 1'b1;
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    // row buffers: land read data, wrap to saved row 0, slide window down
    always_ff @(posedge clk)
    begin
        if (ld_pend_reg)
        begin
            case (ld_tgt_pend_reg)
                LD_UP:
                begin
                    row_up_reg[ld_idx_pend_reg] <= rd_data;
                end
                LD_MID:
                begin
                    row_mid_reg[ld_idx_pend_reg] <= rd_data;
                    row0_reg[ld_idx_pend_reg]    <= rd_data;
                end
                default:
                begin
                    row_dn_reg[ld_idx_pend_reg] <= rd_data;
                end
            endcase
        end
        if ((state_reg == S_ROW) && row_last)
        begin
            row_dn_reg <= row0_reg;
        end
        if ((state_reg == S_CALC) && col_last && !row_last)
        begin
            row_up_reg  <= row_mid_reg;
            row_mid_reg <= row_dn_reg;
        end
    end

    assign busy         = (state_reg != S_IDLE);
    assign done         = done_reg;
    assign cell_alive   = alive_reg;
    assign done_command = done_cmd_reg;

    // checks
    `LIFEGEN_ASSERT_HOLD(a_done_when_idle, clk, rst_n, done_reg, state_reg == S_IDLE, "result beat while busy")
    `LIFEGEN_ASSERT_NEXT(a_accept_goes_busy, clk, rst_n, start && !busy, state_reg == S_ACCESS, "accepted command not started")
    `LIFEGEN_ASSERT_HOLD(a_no_same_cell_rw, clk, rst_n, ram_wr.en && ram_rd.en, ram_wr.addr != ram_rd.addr, "read and write hit the same cell")
    `LIFEGEN_ASSERT_HOLD(a_alive_only_read, clk, rst_n, done_reg && (done_cmd_reg != CMD_READ), !alive_reg, "live flag on non-read result")

endmodule

/* sim/tb_top.sv */
module tb_top;
    import lifegen_pkg::*;

    localparam int RANDOM_ITEMS = 115;

    // one result beat as the block should report it
    typedef struct packed {
        logic alive;
        cmd_t op;
    } result_beat_t;

    // one line of the directed stimulus: a register write or a command
    typedef struct packed {
        logic                  is_reg;
        logic [CFG_ADDR_W-1:0] sel;
        logic [CFG_W-1:0]      val;
        cmd_t                  op;
        logic [5:0]            x;
        logic [5:0]            y;
        logic                  v;
        logic                  known;
        logic                  alive;
    } plan_row_t;

    logic                  clk = 1'b0;
    logic                  rst_n = 1'b0;
    logic                  start = 1'b0;
    logic                  busy;
    logic [1:0]            command = CMD_NOP;
    logic [5:0]            cell_x = '0;
    logic [5:0]            cell_y = '0;
    logic                  cell_value = 1'b0;
    logic                  cfg_wr_en = 1'b0;
    logic [CFG_ADDR_W-1:0] cfg_addr = REG_GRID_COLS;
    logic [CFG_W-1:0]      cfg_wdata = '0;
    logic                  done;
    logic                  cell_alive;
    logic [1:0]            done_command;

    life_automaton_generation_unit dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .start        (start),
        .busy         (busy),
        .command      (command),
        .cell_x       (cell_x),
        .cell_y       (cell_y),
        .cell_value   (cell_value),
        .cfg_wr_en    (cfg_wr_en),
        .cfg_addr     (cfg_addr),
        .cfg_wdata    (cfg_wdata),
        .done         (done),
        .cell_alive   (cell_alive),
        .done_command (done_command)
    );

    // clock, period 12
    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    // grid mirror and size registers
    bit               model_cells [CELL_COUNT];
    logic [CFG_W-1:0] cols_setting = SIZE_RESET;
    logic [CFG_W-1:0] rows_setting = SIZE_RESET;

    result_beat_t awaited_results [$];
    int           error_count = 0;
    bit           calm = 1'b0;

    task automatic flag_mismatch(input string what);
        $display("mismatch at %0t: %s", $realtime, what);
        error_count++;
    endtask

    // size register to size in use
    function automatic int clamp_dim(input logic [CFG_W-1:0] raw, input int hi);
        if (int'(raw) < MIN_SIZE)
            return MIN_SIZE;
        if (int'(raw) > hi)
            return hi;
        return int'(raw);
    endfunction

    function automatic bit cell_at(input int x, input int y, input int cols);
        int idx;
        idx = y * cols + x;
        if (idx >= CELL_COUNT)
            return 1'b0;
        return model_cells[idx];
    endfunction

    // one generation on the torus, built in a scratch grid then copied back
    function automatic void evolve_grid(input int cols, input int rows);
        bit fresh [CELL_COUNT];
        int x, y, dx, dy, n;
        bit s;
        for (y = 0; y < rows; y++)
            for (x = 0; x < cols; x++)
            begin
                n = 0;
                for (dy = -1; dy <= 1; dy++)
                    for (dx = -1; dx <= 1; dx++)
                        if (dx != 0 || dy != 0)
                            n += cell_at((x + dx + cols) % cols, (y + dy + rows) % rows, cols);
                s = cell_at(x, y, cols);
                if (!s && n == BIRTH_COUNT)
                    fresh[y * cols + x] = 1'b1;
                else if (s && (n < SURVIVE_MIN || n > BIRTH_COUNT))
                    fresh[y * cols + x] = 1'b0;
                else
                    fresh[y * cols + x] = s;
            end
        for (y = 0; y < rows; y++)
            for (x = 0; x < cols; x++)
                model_cells[y * cols + x] = fresh[y * cols + x];
    endfunction

    // apply one command to the mirror, return the expected cell_alive
    function automatic logic apply_life_cmd(input cmd_t op, input logic [5:0] x,
                                            input logic [5:0] y, input logic v);
        int   cols, rows;
        bit   in_grid;
        logic alive;
        cols    = clamp_dim(cols_setting, MAX_COLS);
        rows    = clamp_dim(rows_setting, MAX_ROWS);
        in_grid = (int'(x) < cols) && (int'(y) < rows);
        alive   = 1'b0;
        case (op)
            CMD_WRITE: if (in_grid) model_cells[int'(y) * cols + int'(x)] = v;
            CMD_READ:  if (in_grid) alive = cell_at(int'(x), int'(y), cols);
            CMD_STEP:  evolve_grid(cols, rows);
            default:   ;
        endcase
        return alive;
    endfunction

    // size register value: mostly small grids, sometimes the extremes
    function automatic logic [CFG_W-1:0] pick_size();
        if ($urandom_range(0, 9) < 7)
            return CFG_W'($urandom_range(3, 10));
        case ($urandom_range(0, 8))
            0:       return 7'd0;
            1:       return 7'd1;
            2:       return 7'd2;
            3:       return 7'd3;
            4:       return 7'd63;
            5:       return 7'd64;
            6:       return 7'd65;
            7:       return 7'd127;
            default: return CFG_W'($urandom_range(0, 127));
        endcase
    endfunction

    function automatic plan_row_t op_row(input cmd_t op, input logic [5:0] x,
                                         input logic [5:0] y, input logic v,
                                         input logic known, input logic alive);
        plan_row_t row;
        row       = '0;
        row.op    = op;
        row.x     = x;
        row.y     = y;
        row.v     = v;
        row.known = known;
        row.alive = alive;
        return row;
    endfunction

    function automatic plan_row_t reg_row(input logic [CFG_ADDR_W-1:0] sel,
                                          input logic [CFG_W-1:0] val);
        plan_row_t row;
        row        = '0;
        row.is_reg = 1'b1;
        row.sel    = sel;
        row.val    = val;
        return row;
    endfunction

    // drop start and wait for the block to drain
    task automatic settle_idle();
        @(negedge clk);
        start <= 1'b0;
        while (awaited_results.size() != 0 || busy)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic set_reg(input logic [CFG_ADDR_W-1:0] sel, input logic [CFG_W-1:0] val);
        @(negedge clk);
        cfg_wr_en <= 1'b1;
        cfg_addr  <= sel;
        cfg_wdata <= val;
        @(negedge clk);
        cfg_wr_en <= 1'b0;
        if (sel == REG_GRID_COLS)
            cols_setting = val;
        else
            rows_setting = val;
    endtask

    // send one command beat, record its expected result once taken
    task automatic issue(input cmd_t op, input logic [5:0] x, input logic [5:0] y,
                         input logic v, input logic known, input logic known_alive);
        int           gap;
        result_beat_t beat;
        gap = (!calm && $urandom_range(0, 3) == 0) ? $urandom_range(1, 3) : 0;
        if (gap > 0)
        begin
            @(negedge clk);
            start <= 1'b0;
            repeat (gap - 1) @(negedge clk);
        end
        @(negedge clk);
        start      <= 1'b1;
        command    <= op;
        cell_x     <= x;
        cell_y     <= y;
        cell_value <= v;
        @(posedge clk);
        while (busy)
            @(posedge clk);
        beat.alive = apply_life_cmd(op, x, y, v);
        beat.op    = op;
        if (known)
            beat.alive = known_alive;
        awaited_results.push_back(beat);
    endtask

    // result checker
    always @(posedge clk)
    begin
        result_beat_t head;
        if (rst_n && done)
        begin
            if (awaited_results.size() == 0)
                flag_mismatch("result beat with nothing pending");
            else
            begin
                head = awaited_results.pop_front();
                if (cell_alive !== head.alive)
                    flag_mismatch($sformatf("cell_alive %b, wanted %b for %s",
                                            cell_alive, head.alive, head.op.name()));
                if (done_command !== head.op)
                    flag_mismatch($sformatf("done_command %0d, wanted %0d",
                                            done_command, head.op));
            end
        end
    end

    // stimulus
    initial
    begin : stimulus
        plan_row_t  directed_plan [$];
        plan_row_t  row;
        int         random_sent, batch, steps_left, cols, rows, pick, i;
        cmd_t       op;
        logic [5:0] x, y;

        repeat (3) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // reset state, out of range, unused code
        directed_plan.push_back(op_row(CMD_READ, 6'd0, 6'd0, 1'b0, 1'b1, 1'b0));
        directed_plan.push_back(op_row(CMD_READ, 6'd63, 6'd63, 1'b0, 1'b1, 1'b0));
        directed_plan.push_back(op_row(CMD_NOP, 6'd63, 6'd63, 1'b1, 1'b1, 1'b0));
        directed_plan.push_back(op_row(CMD_WRITE, 6'd49, 6'd49, 1'b1, 1'b1, 1'b0));
        directed_plan.push_back(op_row(CMD_READ, 6'd49, 6'd49, 1'b0, 1'b1, 1'b1));
        directed_plan.push_back(op_row(CMD_WRITE, 6'd50, 6'd3, 1'b1, 1'b1, 1'b0));
        directed_plan.push_back(op_row(CMD_READ, 6'd50, 6'd3, 1'b0, 1'b1, 1'b0));
        // three-cell row across the left-right wrap beside the live corner cell, one step
        directed_plan.push_back(op_row(CMD_WRITE, 6'd49, 6'd0, 1'b1, 1'b0, 1'b0));
        directed_plan.push_back(op_row(CMD_WRITE, 6'd0, 6'd0, 1'b1, 1'b0, 1'b0));
        directed_plan.push_back(op_row(CMD_WRITE, 6'd1, 6'd0, 1'b1, 1'b0, 1'b0));
        directed_plan.push_back(op_row(CMD_STEP, 6'd0, 6'd0, 1'b0, 1'b1, 1'b0));
        directed_plan.push_back(op_row(CMD_READ, 6'd0, 6'd49, 1'b0, 1'b0, 1'b0));
        directed_plan.push_back(op_row(CMD_READ, 6'd0, 6'd1, 1'b0, 1'b0, 1'b0));
        directed_plan.push_back(op_row(CMD_READ, 6'd49, 6'd49, 1'b0, 1'b0, 1'b0));
        // size registers below and above range
        directed_plan.push_back(reg_row(REG_GRID_COLS, 7'd0));
        directed_plan.push_back(reg_row(REG_GRID_ROWS, 7'd127));
        directed_plan.push_back(op_row(CMD_WRITE, 6'd2, 6'd63, 1'b1, 1'b0, 1'b0));
        directed_plan.push_back(op_row(CMD_READ, 6'd2, 6'd63, 1'b0, 1'b0, 1'b0));
        directed_plan.push_back(op_row(CMD_READ, 6'd3, 6'd0, 1'b0, 1'b1, 1'b0));
        // widen the grid: old cells seen through the new mapping
        directed_plan.push_back(reg_row(REG_GRID_COLS, 7'd64));
        directed_plan.push_back(op_row(CMD_READ, 6'd63, 6'd2, 1'b0, 1'b0, 1'b0));
        directed_plan.push_back(op_row(CMD_WRITE, 6'd63, 6'd63, 1'b1, 1'b0, 1'b0));
        directed_plan.push_back(op_row(CMD_WRITE, 6'd63, 6'd63, 1'b0, 1'b0, 1'b0));
        directed_plan.push_back(op_row(CMD_WRITE, 6'd0, 6'd1, 1'b1, 1'b0, 1'b0));
        directed_plan.push_back(op_row(CMD_STEP, 6'd0, 6'd0, 1'b0, 1'b0, 1'b0));
        directed_plan.push_back(op_row(CMD_READ, 6'd1, 6'd1, 1'b0, 1'b0, 1'b0));
        directed_plan.push_back(reg_row(REG_GRID_COLS, 7'd65));
        directed_plan.push_back(reg_row(REG_GRID_ROWS, 7'd2));
        directed_plan.push_back(op_row(CMD_STEP, 6'd0, 6'd0, 1'b0, 1'b0, 1'b0));
        directed_plan.push_back(op_row(CMD_READ, 6'd0, 6'd0, 1'b0, 1'b0, 1'b0));

        foreach (directed_plan[k])
        begin
            row = directed_plan[k];
            if (row.is_reg)
            begin
                if (k == 0 || !directed_plan[k - 1].is_reg)
                    settle_idle();
                set_reg(row.sel, row.val);
            end
            else
                issue(row.op, row.x, row.y, row.v, row.known, row.alive);
        end

        // random phases, one size setting each
        random_sent = 0;
        while (random_sent < RANDOM_ITEMS)
        begin
            settle_idle();
            set_reg(REG_GRID_COLS, pick_size());
            set_reg(REG_GRID_ROWS, pick_size());
            cols       = clamp_dim(cols_setting, MAX_COLS);
            rows       = clamp_dim(rows_setting, MAX_ROWS);
            steps_left = (cols * rows > 256) ? 1 : 1000;
            batch      = $urandom_range(6, 16);
            for (i = 0; i < batch && random_sent < RANDOM_ITEMS; i++)
            begin
                calm = (RANDOM_ITEMS - random_sent <= 20);
                pick = $urandom_range(0, 99);
                if (pick < 40)
                    op = CMD_WRITE;
                else if (pick < 75)
                    op = CMD_READ;
                else if (pick < 90 && steps_left > 0)
                begin
                    op = CMD_STEP;
                    steps_left--;
                end
                else if (pick < 90)
                    op = CMD_READ;
                else
                    op = CMD_NOP;
                // mostly cells in use, some anywhere in the field range
                if ($urandom_range(0, 6) == 0)
                begin
                    x = 6'($urandom_range(0, 63));
                    y = 6'($urandom_range(0, 63));
                end
                else
                begin
                    x = 6'($urandom_range(0, cols - 1));
                    y = 6'($urandom_range(0, rows - 1));
                end
                issue(op, x, y, 1'($urandom_range(0, 1)), 1'b0, 1'b0);
                random_sent++;
            end
        end

        // drain and finish
        settle_idle();
        repeat (8) @(posedge clk);
        if (error_count == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

    // watchdog
    initial
    begin
        #24_000_000;
        $display("timeout with %0d results pending", awaited_results.size());
        $display("== FAIL ==");
        $finish;
    end

endmodule

/* life_automaton_generation_unit.f */
+incdir+design
design/lifegen_pkg.sv
design/lifegen_cell_ram.sv
design/lifegen_rule.sv
design/life_automaton_generation_unit.sv
sim/tb_top.sv
